>>> rtl/core/psdc_pkg.sv
// ----------------------------------------------------------------------------
// psdc_pkg
// Shared types, constants and the byte-wide CRC-32/MPEG-2 update for the
// PSI section deframer.
// ----------------------------------------------------------------------------
package psdc_pkg;

   localparam logic [31:0] CRC_POLY     = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
   localparam logic [11:0] LEN_LIMIT    = 12'd1021;
   localparam logic [12:0] HEADER_BYTES = 13'd3;

   localparam int RSP_DEPTH = 3;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_LVL_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic       length_error;
      logic       crc_ok;
      logic       section_end;
      logic [9:0] byte_index;
      logic [7:0] section_byte;
   } rsp_type;

   typedef struct packed {
      logic       unit_start;
      logic       packet_first;
      logic       action;
      logic [7:0] payload_byte;
   } req_type;

   // MSB-first, no reflection
   function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                            input logic [7:0]  data);
      logic [31:0] crc;
      logic        top;
      crc = crc_in;
      for (int i = 0; i < 8; i++) begin
         top = data[7 - i] ^ crc[31];
         crc = {crc[30:0], 1'b0} ^ (top ? CRC_POLY : 32'h0);
      end
      return crc;
   endfunction

endpackage

>>> rtl/core/psdc_parser.sv
// ----------------------------------------------------------------------------
// psdc_parser
// Input beat register and section parser: pointer skip, length capture,
// running CRC and result generation, one byte per cycle while the result buffer has room.
// ----------------------------------------------------------------------------
module psdc_parser
   import psdc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req,
   input  logic [RSP_LVL_W-1:0] rsp_level,
   output logic                 push,
   output rsp_type              push_data
);

   logic        in_valid_ff, in_valid_in;
   req_type     in_ff;

   logic        waiting_ff, waiting_in;
   logic [7:0]  skip_ff, skip_in;
   logic [9:0]  taken_ff, taken_in;
   logic [11:0] len_ff, len_in;
   logic [31:0] crc_ff, crc_in;

   logic [RSP_LVL_W:0] level_sum;
   logic [31:0]        crc_next;
   logic [11:0]        len_cur;
   logic               is_end;
   logic               is_lerr;

   assign level_sum = {1'b0, rsp_level} + {{RSP_LVL_W{1'b0}}, in_valid_ff};
   assign req_ready = level_sum < (RSP_LVL_W + 1)'(RSP_DEPTH);
   assign in_valid_in = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (in_valid_in) begin
         in_ff <= req;
      end
   end

   assign crc_next = crc_byte(crc_ff, in_ff.payload_byte);

   always_comb begin
      len_cur = len_ff;
      if (taken_ff == 10'd1) begin
         len_cur = {in_ff.payload_byte[3:0], 8'h00};
      end else if (taken_ff == 10'd2) begin
         len_cur = len_ff | {4'h0, in_ff.payload_byte};
      end
      is_lerr = (taken_ff == 10'd2) && (len_cur >= LEN_LIMIT);
      is_end  = is_lerr || ((taken_ff >= 10'd2) &&
                ({3'b000, taken_ff} == ({1'b0, len_cur} + HEADER_BYTES - 13'd1)));
   end

   always_comb begin
      waiting_in = waiting_ff;
      skip_in    = skip_ff;
      taken_in   = taken_ff;
      len_in     = len_ff;
      crc_in     = crc_ff;
      push       = 1'b0;

      push_data.section_byte = in_ff.payload_byte;
      push_data.byte_index   = taken_ff;
      push_data.section_end  = is_end;
      push_data.crc_ok       = is_end && !is_lerr && (crc_next == 32'h0);
      push_data.length_error = is_lerr;

      if (in_valid_ff) begin
         if (in_ff.action || (in_ff.packet_first && in_ff.unit_start)) begin
            waiting_in = in_ff.action;
            skip_in    = in_ff.action ? 8'h00 : in_ff.payload_byte;
            taken_in   = 10'd0;
            len_in     = 12'd0;
            crc_in     = CRC_INIT;
         end else if (waiting_ff) begin
            waiting_in = 1'b1;
         end else if (skip_ff != 8'h00) begin
            skip_in = skip_ff - 8'd1;
         end else begin
            push = 1'b1;
            if (is_end) begin
               waiting_in = 1'b1;
               skip_in    = 8'h00;
               taken_in   = 10'd0;
               len_in     = 12'd0;
               crc_in     = CRC_INIT;
            end else begin
               taken_in = taken_ff + 10'd1;
               len_in   = len_cur;
               crc_in   = crc_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff <= 1'b1;
         skip_ff    <= 8'h00;
         taken_ff   <= 10'd0;
         len_ff     <= 12'd0;
         crc_ff     <= CRC_INIT;
      end else begin
         waiting_ff <= waiting_in;
         skip_ff    <= skip_in;
         taken_ff   <= taken_in;
         len_ff     <= len_in;
         crc_ff     <= crc_in;
      end
   end

endmodule

>>> rtl/core/psdc_rsp_fifo.sv
// ----------------------------------------------------------------------------
// psdc_rsp_fifo
// Small result buffer between the parser and the output channel.
// ----------------------------------------------------------------------------
module psdc_rsp_fifo
   import psdc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rsp_type              push_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rsp_type              out_data,
   output logic [RSP_LVL_W-1:0] level
);

   rsp_type                mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ff, wr_in;
   logic [RSP_PTR_W-1:0]   rd_ff, rd_in;
   logic [RSP_LVL_W-1:0]   cnt_ff, cnt_in;
   logic                   pop;

   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rd_ff];
   assign level     = cnt_ff;
   assign pop       = out_valid & out_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ff + RSP_PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ff + RSP_PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + RSP_LVL_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - RSP_LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/psi_section_deframer_crc_top.sv
// ----------------------------------------------------------------------------
// psi_section_deframer_crc_top
// PSI section reassembly from transport-stream payload bytes with
// CRC-32/MPEG-2 check.
// ----------------------------------------------------------------------------
// One payload byte is taken per cycle while req_tready is high. A byte goes
// into an input register, is parsed in the next cycle and its section byte,
// if any, is written to a three-entry result buffer that drives rsp_tvalid.
// req_tready drops only when the buffer plus the byte in flight would fill
// it, which happens only while the result side stalls.
module psi_section_deframer_crc_top
   import psdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // payload_byte
   input  logic [2:0]  req_tuser,   // action, packet_first, unit_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // section_byte, byte_index, zero pad
   output logic        rsp_tlast,   // section_end
   output logic [1:0]  rsp_tuser    // crc_ok, length_error
);

   req_type              req;
   rsp_type              push_data;
   rsp_type              out_data;
   logic                 push;
   logic [RSP_LVL_W-1:0] level;

   assign req.payload_byte = req_tdata;
   assign req.action       = req_tuser[0];
   assign req.packet_first = req_tuser[1];
   assign req.unit_start   = req_tuser[2];

   psdc_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .rsp_level (level),
      .push      (push),
      .push_data (push_data)
   );

   psdc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data),
      .level     (level)
   );

   assign rsp_tdata = {6'b000000, out_data.byte_index, out_data.section_byte};
   assign rsp_tlast = out_data.section_end;
   assign rsp_tuser = {out_data.length_error, out_data.crc_ok};

endmodule
